>>> hw/rtl/sprite_sheet_frame_sequencer_defines.svh
// Assertion macros for the sprite sheet frame sequencer checker.
// No dependencies; included by the checker file.
`ifndef SPRITE_SHEET_FRAME_SEQUENCER_DEFINES_SVH
`define SPRITE_SHEET_FRAME_SEQUENCER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SSFS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssfs: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define SSFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssfs: next-cycle check failed");

`endif

>>> hw/rtl/ssfs_pkg.sv
// Package for the sprite sheet frame sequencer: widths, codes, structs, helpers.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ssfs_pkg;

   localparam int MAX_COLS   = 64;
   localparam int MAX_ROWS   = 64;

   localparam int PERIOD_W   = 27;
   localparam int DIM_W      = 7;
   localparam int COORD_W    = 12;
   localparam int SIZE_W     = 13;
   localparam int FRAME_W    = 12;
   localparam int DELTA_W    = 20;
   localparam int OP_W       = 3;
   localparam int RECT_W     = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 27;

   localparam int CELLS_W    = 2 * DIM_W;
   localparam int PROD_X_W   = DIM_W + SIZE_W;
   localparam int PROD_Y_W   = FRAME_W + SIZE_W;
   localparam int SUM_W      = PROD_Y_W + 1;

   localparam int DIV_STEPS  = (SIZE_W + 1) / 2;
   localparam int DIV_PAD_W  = 2 * DIV_STEPS;
   localparam int DIV_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   localparam logic [FRAME_W-1:0]  FRAME_MAX    = '1;
   localparam logic [RECT_W-1:0]   RECT_MAX     = '1;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100000);

   typedef enum logic [OP_W-1:0] {
      OP_TICK      = 3'd0,
      OP_SET_FRAME = 3'd1,
      OP_RESTART   = 3'd2,
      OP_PAUSE     = 3'd3,
      OP_RESUME    = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_PERIOD = 3'd0,
      CSR_GRID_COLS    = 3'd1,
      CSR_GRID_ROWS    = 3'd2,
      CSR_LOOP_ENABLE  = 3'd3,
      CSR_SHEET_X      = 3'd4,
      CSR_SHEET_Y      = 3'd5,
      CSR_SHEET_W      = 3'd6,
      CSR_SHEET_H      = 3'd7
   } csr_index_type;

   // Effective configuration: grid clamped, sheet size never zero.
   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [DIM_W-1:0]    cols;
      logic [DIM_W-1:0]    rows;
      logic                loop_en;
      logic [COORD_W-1:0]  sheet_x;
      logic [COORD_W-1:0]  sheet_y;
      logic [SIZE_W-1:0]   sheet_w;
      logic [SIZE_W-1:0]   sheet_h;
   } cfg_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               done;
      logic               updated;
   } anim_status_type;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] quotient;
      logic [DIM_W-1:0]  remainder;
   } div_result_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > hi) begin
         r = DIM_W'(hi);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [SIZE_W-1:0] nonzero_size(input logic [SIZE_W-1:0] v);
      return (v == '0) ? SIZE_W'(1) : v;
   endfunction

endpackage

>>> hw/rtl/ssfs_div.sv
// Shared iterative divider, two quotient bits per cycle (restoring).
// Depends on ssfs_pkg.
`timescale 1ns / 1ps

module ssfs_div import ssfs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SIZE_W-1:0]   dividend,
   input  logic [DIM_W-1:0]    divisor,
   output div_result_type      result
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_PAD_W-1:0]  shift_ff, shift_in;
   logic [DIM_W-1:0]      rem_ff, rem_in;
   logic [DIM_W-1:0]      dsr_ff, dsr_in;

   logic [DIM_W:0]        a0, a1;
   logic                  q1, q2;
   logic [DIM_W-1:0]      r1, r2;

   always_comb begin
      a0 = {rem_ff, shift_ff[DIV_PAD_W-1]};
      q1 = (a0 >= {1'b0, dsr_ff});
      r1 = q1 ? DIM_W'(a0 - {1'b0, dsr_ff}) : a0[DIM_W-1:0];
      a1 = {r1, shift_ff[DIV_PAD_W-2]};
      q2 = (a1 >= {1'b0, dsr_ff});
      r2 = q2 ? DIM_W'(a1 - {1'b0, dsr_ff}) : a1[DIM_W-1:0];

      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;

      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = DIV_PAD_W'(dividend);
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         shift_in = {shift_ff[DIV_PAD_W-3:0], q1, q2};
         rem_in   = r2;
         cnt_in   = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = shift_ff[SIZE_W-1:0];
   assign result.remainder = rem_ff;

endmodule

>>> hw/rtl/ssfs_anim.sv
// Configuration registers and animation state (timer, frame, done, pause).
// Depends on ssfs_pkg.
`timescale 1ns / 1ps

module ssfs_anim import ssfs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  accept,
   input  logic [OP_W-1:0]       operation,
   input  logic [DELTA_W-1:0]    delta_time,
   input  logic [FRAME_W-1:0]    target_frame,
   output cfg_type               cfg,
   output anim_status_type       status
);

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [DIM_W-1:0]    cols_ff, cols_in;
   logic [DIM_W-1:0]    rows_ff, rows_in;
   logic                loop_ff, loop_in;
   logic [COORD_W-1:0]  sx_ff, sx_in;
   logic [COORD_W-1:0]  sy_ff, sy_in;
   logic [SIZE_W-1:0]   sw_ff, sw_in;
   logic [SIZE_W-1:0]   sh_ff, sh_in;

   logic [PERIOD_W-1:0] elapsed_ff, elapsed_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic                done_ff, done_in;
   logic                paused_ff, paused_in;
   logic                updated_ff, updated_in;

   logic [DIM_W-1:0]    cols_eff, rows_eff;
   logic [CELLS_W-1:0]  cells, cells_m1;
   logic [FRAME_W-1:0]  last;
   logic [PERIOD_W:0]   sum;
   logic [PERIOD_W-1:0] sat;

   always_comb begin
      period_in = period_ff;
      cols_in   = cols_ff;
      rows_in   = rows_ff;
      loop_in   = loop_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      sw_in     = sw_ff;
      sh_in     = sh_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_PERIOD: period_in = csr_data[PERIOD_W-1:0];
            CSR_GRID_COLS:    cols_in   = csr_data[DIM_W-1:0];
            CSR_GRID_ROWS:    rows_in   = csr_data[DIM_W-1:0];
            CSR_LOOP_ENABLE:  loop_in   = csr_data[0];
            CSR_SHEET_X:      sx_in     = csr_data[COORD_W-1:0];
            CSR_SHEET_Y:      sy_in     = csr_data[COORD_W-1:0];
            CSR_SHEET_W:      sw_in     = csr_data[SIZE_W-1:0];
            CSR_SHEET_H:      sh_in     = csr_data[SIZE_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      cols_eff = clamp_dim(cols_ff, MAX_COLS);
      rows_eff = clamp_dim(rows_ff, MAX_ROWS);
      cells    = CELLS_W'(cols_eff) * CELLS_W'(rows_eff);
      cells_m1 = cells - CELLS_W'(1);
      last     = (cells_m1 > CELLS_W'(FRAME_MAX)) ? FRAME_MAX : cells_m1[FRAME_W-1:0];
      sum      = (PERIOD_W+1)'(elapsed_ff) + (PERIOD_W+1)'(delta_time);
      sat      = sum[PERIOD_W] ? '1 : sum[PERIOD_W-1:0];

      elapsed_in = elapsed_ff;
      frame_in   = frame_ff;
      done_in    = done_ff;
      paused_in  = paused_ff;
      updated_in = updated_ff;

      if (accept) begin
         updated_in = 1'b0;
         case (op_type'(operation))
            OP_TICK: begin
               if (!paused_ff) begin
                  elapsed_in = sat;
                  if (period_ff < sat) begin
                     elapsed_in = '0;
                     updated_in = 1'b1;
                     if (frame_ff >= last) begin
                        if (loop_ff) begin
                           frame_in = '0;
                        end else begin
                           frame_in = last;
                           done_in  = 1'b1;
                        end
                     end else begin
                        frame_in = frame_ff + FRAME_W'(1);
                     end
                  end
               end
            end
            OP_SET_FRAME: begin
               done_in    = 1'b0;
               elapsed_in = '0;
               frame_in   = (target_frame > last) ? last : target_frame;
               updated_in = 1'b1;
            end
            OP_RESTART: begin
               done_in    = 1'b0;
               elapsed_in = '0;
               frame_in   = '0;
               updated_in = 1'b1;
            end
            OP_PAUSE:  paused_in = 1'b1;
            OP_RESUME: paused_in = 1'b0;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         cols_ff    <= DIM_W'(1);
         rows_ff    <= DIM_W'(1);
         loop_ff    <= 1'b1;
         sx_ff      <= '0;
         sy_ff      <= '0;
         sw_ff      <= SIZE_W'(1);
         sh_ff      <= SIZE_W'(1);
         elapsed_ff <= '0;
         frame_ff   <= '0;
         done_ff    <= 1'b0;
         paused_ff  <= 1'b0;
         updated_ff <= 1'b0;
      end else begin
         period_ff  <= period_in;
         cols_ff    <= cols_in;
         rows_ff    <= rows_in;
         loop_ff    <= loop_in;
         sx_ff      <= sx_in;
         sy_ff      <= sy_in;
         sw_ff      <= sw_in;
         sh_ff      <= sh_in;
         elapsed_ff <= elapsed_in;
         frame_ff   <= frame_in;
         done_ff    <= done_in;
         paused_ff  <= paused_in;
         updated_ff <= updated_in;
      end
   end

   assign cfg.period  = period_ff;
   assign cfg.cols    = cols_eff;
   assign cfg.rows    = rows_eff;
   assign cfg.loop_en = loop_ff;
   assign cfg.sheet_x = sx_ff;
   assign cfg.sheet_y = sy_ff;
   assign cfg.sheet_w = nonzero_size(sw_ff);
   assign cfg.sheet_h = nonzero_size(sh_ff);

   assign status.frame   = frame_ff;
   assign status.done    = done_ff;
   assign status.updated = updated_ff;

endmodule

>>> hw/rtl/sprite_sheet_frame_sequencer.sv
// Top level of the sprite sheet frame sequencer: sequencer, product stage, result register.
// Depends on ssfs_pkg, ssfs_anim and ssfs_div.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | operation, delta_time, target_frame
//   rsp     | out       | rsp_valid/rsp_stall | frame_index, rect_x/y/w/h, loop_complete,
//           |           |                     | rect_updated
//   csr     | in        | csr_write           | csr_index, csr_data
//
// For each item, the result is registered after three passes through the shared
// two-bit-per-cycle divider (7 steps and a hand-off each: width, height, frame by
// columns), the multiply state and the output register write.
// req_stall is high from the transfer until the result is written to the output register.
// The output register holds a result under rsp_stall while the next item is taken;
// the sequencer waits before writing only if that result is still not taken.
// Reset is synchronous and clears control state and configuration to defaults.
`timescale 1ns / 1ps

module sprite_sheet_frame_sequencer import ssfs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [DELTA_W-1:0]    req_delta_time,
   input  logic [FRAME_W-1:0]    req_target_frame,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [FRAME_W-1:0]    rsp_frame_index,
   output logic [RECT_W-1:0]     rsp_rect_x,
   output logic [RECT_W-1:0]     rsp_rect_y,
   output logic [RECT_W-1:0]     rsp_rect_w,
   output logic [RECT_W-1:0]     rsp_rect_h,
   output logic                  rsp_loop_complete,
   output logic                  rsp_rect_updated,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIV_W = 6'b000010,
      ST_DIV_H = 6'b000100,
      ST_DIV_F = 6'b001000,
      ST_MULT  = 6'b010000,
      ST_OUT   = 6'b100000
   } seq_state_type;

   seq_state_type        state_ff, state_in;
   logic                 req_accept;

   cfg_type              cfg;
   anim_status_type      status;
   div_result_type       div_res;
   logic                 div_start;
   logic [SIZE_W-1:0]    div_dividend;
   logic [DIM_W-1:0]     div_divisor;

   logic [SIZE_W-1:0]    fw_ff, fw_in;
   logic [SIZE_W-1:0]    fh_ff, fh_in;
   logic [DIM_W-1:0]     col_ff, col_in;
   logic [FRAME_W-1:0]   row_ff, row_in;
   logic [PROD_X_W-1:0]  px_ff, px_in;
   logic [PROD_Y_W-1:0]  py_ff, py_in;
   logic [SUM_W-1:0]     cx, cy;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [RECT_W-1:0]    rx_ff, rx_in;
   logic [RECT_W-1:0]    ry_ff, ry_in;
   logic [RECT_W-1:0]    rw_ff, rw_in;
   logic [RECT_W-1:0]    rh_ff, rh_in;
   logic                 loop_done_ff, loop_done_in;
   logic                 upd_ff, upd_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   ssfs_anim u_anim (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .accept       (req_accept),
      .operation    (req_operation),
      .delta_time   (req_delta_time),
      .target_frame (req_target_frame),
      .cfg          (cfg),
      .status       (status)
   );

   ssfs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   always_comb begin
      cx = SUM_W'(px_ff) + SUM_W'(cfg.sheet_x);
      cy = SUM_W'(py_ff) + SUM_W'(cfg.sheet_y);

      state_in     = state_ff;
      div_start    = 1'b0;
      div_dividend = cfg.sheet_w;
      div_divisor  = cfg.cols;
      fw_in        = fw_ff;
      fh_in        = fh_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      px_in        = px_ff;
      py_in        = py_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      frame_in     = frame_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rw_in        = rw_ff;
      rh_in        = rh_ff;
      loop_done_in = loop_done_ff;
      upd_in       = upd_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               div_start = 1'b1;
               state_in  = ST_DIV_W;
            end
         end
         ST_DIV_W: begin
            if (div_res.done) begin
               fw_in        = div_res.quotient;
               div_start    = 1'b1;
               div_dividend = cfg.sheet_h;
               div_divisor  = cfg.rows;
               state_in     = ST_DIV_H;
            end
         end
         ST_DIV_H: begin
            if (div_res.done) begin
               fh_in        = div_res.quotient;
               div_start    = 1'b1;
               div_dividend = SIZE_W'(status.frame);
               div_divisor  = cfg.cols;
               state_in     = ST_DIV_F;
            end
         end
         ST_DIV_F: begin
            if (div_res.done) begin
               col_in   = div_res.remainder;
               row_in   = div_res.quotient[FRAME_W-1:0];
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            px_in    = PROD_X_W'(col_ff) * PROD_X_W'(fw_ff);
            py_in    = PROD_Y_W'(row_ff) * PROD_Y_W'(fh_ff);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               frame_in     = status.frame;
               rx_in        = (cx > SUM_W'(RECT_MAX)) ? RECT_MAX : cx[RECT_W-1:0];
               ry_in        = (cy > SUM_W'(RECT_MAX)) ? RECT_MAX : cy[RECT_W-1:0];
               rw_in        = fw_ff;
               rh_in        = fh_ff;
               loop_done_in = status.done;
               upd_in       = status.updated;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fw_ff        <= fw_in;
      fh_ff        <= fh_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      frame_ff     <= frame_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      rw_ff        <= rw_in;
      rh_ff        <= rh_in;
      loop_done_ff <= loop_done_in;
      upd_ff       <= upd_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_index   = frame_ff;
   assign rsp_rect_x        = rx_ff;
   assign rsp_rect_y        = ry_ff;
   assign rsp_rect_w        = rw_ff;
   assign rsp_rect_h        = rh_ff;
   assign rsp_loop_complete = loop_done_ff;
   assign rsp_rect_updated  = upd_ff;

endmodule

>>> hw/rtl/ssfs_checker.sv
// Port-level checker for the sprite sheet frame sequencer, bound to the top level.
// Depends on ssfs_pkg and sprite_sheet_frame_sequencer_defines.svh.
`timescale 1ns / 1ps
`include "sprite_sheet_frame_sequencer_defines.svh"

module ssfs_checker import ssfs_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [FRAME_W-1:0] rsp_frame_index
);

   // block is busy right after taking a transfer
   `SSFS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   // a new result only appears at the end of a busy period
   `SSFS_ASSERT_SAME(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

   `SSFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_frame_index))

endmodule

bind sprite_sheet_frame_sequencer ssfs_checker u_ssfs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_frame_index (rsp_frame_index)
);
